[design/kplp_pkg.sv]
// Shared types and constants for the key press and long-press classifier.
package kplp_pkg;

   // Hard limit on matrix positions, matching the 48-bit valid key mask.
   localparam int unsigned MaxKeys = 48;

   // Field widths.
   localparam int unsigned KeyW  = 6;
   localparam int unsigned KindW = 2;
   localparam int unsigned TimeW = 32;
   localparam int unsigned MsW   = 16;
   localparam int unsigned MaskW = 48;

   // Event kinds.
   localparam logic [KindW-1:0] KIND_DOWN = 2'd0;
   localparam logic [KindW-1:0] KIND_UP   = 2'd1;
   localparam logic [KindW-1:0] KIND_LONG = 2'd2;

   // Configuration register indexes.
   localparam int unsigned CsrIndexW = 2;
   localparam logic [CsrIndexW-1:0] CSR_LONG_PRESS_MS  = 2'd0;
   localparam logic [CsrIndexW-1:0] CSR_RELEASE_MIN_MS = 2'd1;
   localparam logic [CsrIndexW-1:0] CSR_VALID_KEY_MASK = 2'd2;
   localparam logic [CsrIndexW-1:0] CSR_DOWN_ONLY_KEY  = 2'd3;

   // Register reset values.
   localparam logic [MsW-1:0]   LONG_PRESS_MS_RST  = 16'd500;
   localparam logic [MsW-1:0]   RELEASE_MIN_MS_RST = 16'd100;
   localparam logic [MaskW-1:0] VALID_KEY_MASK_RST = 48'd151456011897289;
   localparam logic [KeyW-1:0]  DOWN_ONLY_KEY_RST  = 6'd40;

   // Per-key state word held in the state memory.
   typedef struct packed {
      logic [TimeW-1:0] press_time;
      logic             held;
      logic             long_hit;
   } key_state_type;

endpackage

[design/key_press_long_press_classifier_core.sv]
// Key press / long-press classifier: state memory, update stage and result register.
//
// Usage: each req_ transaction carries one scan sample (key position, pressed
// flag, millisecond time). The block keeps per-key press time, held and long
// flags in a synchronous state memory and gives at most one rsp_ transaction
// per sample: Down on a new press, Long once a press lasts beyond
// long_press_ms, Up on a release after more than release_min_ms. Samples for
// positions outside the matrix or the valid mask give nothing.
// A sample is registered in the update stage, then its result in the result
// register that drives rsp_. Throughput: one sample per cycle unless rsp_ stalls.
// The memory is read in the accept cycle and written back from the update stage;
// a one-entry forwarding register covers back-to-back samples for the same key.
// Reset clears the per-entry valid bits at once, so every key reads as idle,
// and loads the configuration defaults; no clearing pass is needed.
// When rsp_tready is low the result register holds, the update stage holds one more
// sample, and req_tready drops until the result is taken. The user must write
// configuration via csr_ while no sample is in flight; the core does not enforce it.
module key_press_long_press_classifier_core #(
   parameter int unsigned SCAN_LINES   = 6,
   parameter int unsigned RETURN_LINES = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   // Sample channel; tdata: key_index[5:0], key_pressed[6], time_ms[38:7], zero pad.
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [39:0]                 req_tdata,
   // Event channel; tdata: event_key[5:0], event_kind[7:6].
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [7:0]                  rsp_tdata,
   // Configuration write port.
   input  logic                        csr_we,
   input  logic [kplp_pkg::CsrIndexW-1:0] csr_index,
   input  logic [kplp_pkg::MaskW-1:0]  csr_wdata
);
   import kplp_pkg::*;

   localparam int unsigned MatrixKeys = SCAN_LINES * RETURN_LINES;
   localparam int unsigned KeyCount   = (MatrixKeys < MaxKeys) ? MatrixKeys : MaxKeys;
   localparam int unsigned AddrW      = (KeyCount > 1) ? $clog2(KeyCount) : 1;

   // Configuration registers.
   logic [MsW-1:0]   long_ms_ff;
   logic [MsW-1:0]   release_ms_ff;
   logic [MaskW-1:0] key_mask_ff;
   logic [KeyW-1:0]  down_only_ff;

   // Input unpacking.
   logic [KeyW-1:0]  in_key;
   logic             in_pressed;
   logic [TimeW-1:0] in_time;
   logic [63:0]      mask_wide;
   logic             in_range;

   // Update stage.
   logic             s1_valid_ff;
   logic [KeyW-1:0]  s1_key_ff;
   logic             s1_pressed_ff;
   logic [TimeW-1:0] s1_time_ff;
   logic             s1_range_ff;

   // State memory, valid bits and forwarding register.
   key_state_type    state_mem [KeyCount];
   logic [KeyCount-1:0] entry_vld_ff;
   key_state_type    rd_data_ff;
   logic             rd_vld_ff;
   logic             fwd_valid_ff;
   logic [KeyW-1:0]  fwd_key_ff;
   key_state_type    fwd_data_ff;

   // Result register.
   logic             rsp_valid_ff;
   logic [KeyW-1:0]  rsp_key_ff;
   logic [KindW-1:0] rsp_kind_ff;

   // Update logic.
   logic             out_free;
   logic             advance;
   logic             s1_fire;
   logic             s1_write;
   key_state_type    cur_state;
   key_state_type    state_in;
   logic [TimeW-1:0] delta;
   logic             emit_raw;
   logic [KindW-1:0] kind_in;
   logic             emit_in;

   assign in_key     = req_tdata[5:0];
   assign in_pressed = req_tdata[6];
   assign in_time    = req_tdata[38:7];
   assign mask_wide  = {{(64 - MaskW){1'b0}}, key_mask_ff};
   assign in_range   = ({26'd0, in_key} < KeyCount) && mask_wide[in_key];

   // Handshake: the stage moves when its sample can hand its result on.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = !s1_valid_ff || out_free;
   assign req_tready = advance;
   assign s1_fire    = s1_valid_ff && out_free;
   assign s1_write   = s1_fire && s1_range_ff;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         long_ms_ff    <= LONG_PRESS_MS_RST;
         release_ms_ff <= RELEASE_MIN_MS_RST;
         key_mask_ff   <= VALID_KEY_MASK_RST;
         down_only_ff  <= DOWN_ONLY_KEY_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LONG_PRESS_MS:  long_ms_ff    <= csr_wdata[MsW-1:0];
            CSR_RELEASE_MIN_MS: release_ms_ff <= csr_wdata[MsW-1:0];
            CSR_VALID_KEY_MASK: key_mask_ff   <= csr_wdata;
            CSR_DOWN_ONLY_KEY:  down_only_ff  <= csr_wdata[KeyW-1:0];
            default: ;
         endcase
      end
   end

   // Update stage control.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   // Update stage payload.
   always_ff @(posedge clock) begin
      if (advance && req_tvalid) begin
         s1_key_ff     <= in_key;
         s1_pressed_ff <= in_pressed;
         s1_time_ff    <= in_time;
         s1_range_ff   <= in_range;
      end
   end

   // Memory read in the accept cycle, write-back from the update stage.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         rd_data_ff <= state_mem[in_key[AddrW-1:0]];
         rd_vld_ff  <= entry_vld_ff[in_key[AddrW-1:0]];
      end
      if (s1_write) begin
         state_mem[s1_key_ff[AddrW-1:0]] <= state_in;
      end
   end

   // Valid bits: an entry never written reads as the idle state.
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_vld_ff <= '0;
      end else if (s1_write) begin
         entry_vld_ff[s1_key_ff[AddrW-1:0]] <= 1'b1;
      end
   end

   // Forwarding register holds the most recent write-back.
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (s1_write) begin
         fwd_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_write) begin
         fwd_key_ff  <= s1_key_ff;
         fwd_data_ff <= state_in;
      end
   end

   // Current key state: forwarded write, memory word, or idle.
   always_comb begin
      if (fwd_valid_ff && (fwd_key_ff == s1_key_ff)) begin
         cur_state = fwd_data_ff;
      end else if (rd_vld_ff) begin
         cur_state = rd_data_ff;
      end else begin
         cur_state = '0;
      end
   end

   assign delta = s1_time_ff - cur_state.press_time;

   // Press classification and next state.
   always_comb begin
      state_in = cur_state;
      emit_raw = 1'b0;
      kind_in  = KIND_DOWN;
      priority if (cur_state.held && !cur_state.long_hit) begin
         if (delta > {16'd0, long_ms_ff}) begin
            state_in.long_hit = 1'b1;
            emit_raw = 1'b1;
            kind_in  = KIND_LONG;
         end else if ((delta > {16'd0, release_ms_ff}) && !s1_pressed_ff) begin
            state_in.held       = 1'b0;
            state_in.press_time = '0;
            emit_raw = 1'b1;
            kind_in  = KIND_UP;
         end
      end else if (s1_pressed_ff && !cur_state.long_hit) begin
         state_in.press_time = s1_time_ff;
         state_in.held       = 1'b1;
         emit_raw = 1'b1;
         kind_in  = KIND_DOWN;
      end else if (!s1_pressed_ff && cur_state.long_hit) begin
         state_in = '0;
      end else begin
         // A key still held after its long press, or an idle key not pressed, keeps its state.
         state_in = cur_state;
      end
   end

   // The down-only key reports Down and nothing else.
   assign emit_in = s1_range_ff && emit_raw
                    && !((s1_key_ff == down_only_ff) && (kind_in != KIND_DOWN));

   // Result register control.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff && emit_in;
      end
   end

   // Result register payload.
   always_ff @(posedge clock) begin
      if (s1_fire && emit_in) begin
         rsp_key_ff  <= s1_key_ff;
         rsp_kind_ff <= kind_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_kind_ff, rsp_key_ff};

endmodule

[test/testbench.sv]
// Self-checking testbench for the key press and long-press classifier core.
`timescale 1ns / 100ps

module testbench;
   import kplp_pkg::*;

   localparam int unsigned ScanLines   = 6;
   localparam int unsigned ReturnLines = 8;
   localparam int unsigned NumKeys     = ScanLines * ReturnLines;
   // Margin for samples still in the core that give no event.
   localparam int unsigned DrainCycles = 4;
   localparam int unsigned HoldCycles  = 60;
   localparam int unsigned StallPct    = 9;

   // Packed like rsp_tdata: kind in the upper bits, key in the lower bits.
   typedef struct packed {
      logic [KindW-1:0] kind;
      logic [KeyW-1:0]  key;
   } key_event_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [39:0]        req_tdata = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b1;
   logic [7:0]         rsp_tdata;
   logic               csr_we = 1'b0;
   logic [CsrIndexW-1:0] csr_index = CSR_LONG_PRESS_MS;
   logic [MaskW-1:0]   csr_wdata = '0;

   // Predicted register values and per-key state.
   logic [MsW-1:0]     long_press_limit;
   logic [MsW-1:0]     release_limit;
   logic [MaskW-1:0]   real_key_mask;
   logic [KeyW-1:0]    silent_key;
   logic [TimeW-1:0]   pressed_at [MaxKeys];
   logic               key_held [MaxKeys];
   logic               long_seen [MaxKeys];

   key_event_type      pending_events[$];
   int                 error_count = 0;
   bit                 quiet_mode = 1'b0;
   bit                 hold_off_request = 1'b0;

   key_press_long_press_classifier_core #(
      .SCAN_LINES   (ScanLines),
      .RETURN_LINES (ReturnLines)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   // Classify one scan sample against the predicted key state; returns 1 when an event results.
   function automatic bit classify_sample(input logic [KeyW-1:0] key, input logic pressed,
                                          input logic [TimeW-1:0] now, output key_event_type ev);
      logic [TimeW-1:0] elapsed;
      ev.key  = key;
      ev.kind = KIND_DOWN;
      if (key >= NumKeys || !real_key_mask[key]) return 1'b0;
      if (key_held[key] && !long_seen[key]) begin
         // Elapsed time wraps modulo 2^32.
         elapsed = now - pressed_at[key];
         if (elapsed > {16'd0, long_press_limit}) begin
            long_seen[key] = 1'b1;
            ev.kind = KIND_LONG;
            return key != silent_key;
         end
         if (elapsed > {16'd0, release_limit} && !pressed) begin
            key_held[key]   = 1'b0;
            pressed_at[key] = '0;
            ev.kind = KIND_UP;
            return key != silent_key;
         end
         return 1'b0;
      end
      if (pressed && !long_seen[key]) begin
         pressed_at[key] = now;
         key_held[key]   = 1'b1;
         return 1'b1;
      end
      // A release after a long press re-arms the key without an event.
      if (!pressed && long_seen[key]) begin
         key_held[key]   = 1'b0;
         long_seen[key]  = 1'b0;
         pressed_at[key] = '0;
      end
      return 1'b0;
   endfunction

   // Track register writes, predict events for accepted samples, and check each event.
   always @(posedge clock) begin : scoreboard
      key_event_type want;
      key_event_type got;
      if (reset) begin
         long_press_limit = LONG_PRESS_MS_RST;
         release_limit    = RELEASE_MIN_MS_RST;
         real_key_mask    = VALID_KEY_MASK_RST;
         silent_key       = DOWN_ONLY_KEY_RST;
         for (int i = 0; i < MaxKeys; i++) begin
            pressed_at[i] = '0;
            key_held[i]   = 1'b0;
            long_seen[i]  = 1'b0;
         end
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_LONG_PRESS_MS:  long_press_limit = csr_wdata[MsW-1:0];
               CSR_RELEASE_MIN_MS: release_limit    = csr_wdata[MsW-1:0];
               CSR_VALID_KEY_MASK: real_key_mask    = csr_wdata;
               CSR_DOWN_ONLY_KEY:  silent_key       = csr_wdata[KeyW-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (classify_sample(req_tdata[5:0], req_tdata[6], req_tdata[38:7], want))
               pending_events.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (pending_events.size() == 0) begin
               $display("%0t: unexpected event key %0d kind %0d, none expected",
                        $time, got.key, got.kind);
               error_count++;
            end else begin
               want = pending_events.pop_front();
               if (got.key !== want.key) begin
                  $display("%0t: event key mismatch, expected %0d, actual %0d",
                           $time, want.key, got.key);
                  error_count++;
               end
               if (got.kind !== want.kind) begin
                  $display("%0t: event kind mismatch, expected %0d, actual %0d",
                           $time, want.kind, got.kind);
                  error_count++;
               end
            end
         end
      end
   end

   // Event receiver: random stalls, or a long hold-off on request.
   initial begin : event_receiver
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= quiet_mode || ($urandom_range(0, 99) >= StallPct);
         end
      end
   end

   // Offer one scan sample and wait for its transaction; valid stays high for the next call.
   task automatic send_sample(input logic [KeyW-1:0] key, input logic pressed,
                              input logic [TimeW-1:0] now);
      while (!quiet_mode && $urandom_range(0, 99) < StallPct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, now, pressed, key};
      do @(posedge clock); while (!req_tready);
   endtask

   // Stop offering samples and wait until every predicted event has arrived.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_events.size() != 0);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_register(input logic [CsrIndexW-1:0] index, input logic [MaskW-1:0] value);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Reset register values: press at time zero, early and late releases, masked and
   // out-of-range positions, and the down-only key.
   task automatic test_default_registers();
      send_sample(6'd0, 1'b1, 32'd0);
      send_sample(6'd0, 1'b0, 32'd50);
      send_sample(6'd0, 1'b0, 32'd101);
      send_sample(6'd1, 1'b1, 32'd10);
      send_sample(6'd63, 1'b1, 32'd20);
      send_sample(6'd48, 1'b1, 32'd20);
      send_sample(6'd40, 1'b1, 32'd1000);
      send_sample(6'd40, 1'b1, 32'd1501);
      send_sample(6'd40, 1'b0, 32'd1600);
      send_sample(6'd40, 1'b1, 32'd1700);
      send_sample(6'd3, 1'b1, 32'd2000);
      send_sample(6'd3, 1'b1, 32'd2600);
      send_sample(6'd3, 1'b0, 32'd2700);
   endtask

   // Register extremes, time wrap, an out-of-range down-only key and an empty mask.
   task automatic test_register_extremes();
      write_register(CSR_LONG_PRESS_MS, '0);
      write_register(CSR_RELEASE_MIN_MS, '0);
      write_register(CSR_VALID_KEY_MASK, {MaskW{1'b1}});
      write_register(CSR_DOWN_ONLY_KEY, 48'd47);
      send_sample(6'd47, 1'b1, 32'hFFFF_FFF0);
      send_sample(6'd47, 1'b1, 32'h0000_0005);
      send_sample(6'd47, 1'b0, 32'h0000_0006);
      send_sample(6'd5, 1'b1, 32'hFFFF_FFFF);
      send_sample(6'd5, 1'b0, 32'hFFFF_FFFF);
      send_sample(6'd5, 1'b0, 32'h0000_0000);
      write_register(CSR_LONG_PRESS_MS, 48'hFFFF);
      write_register(CSR_RELEASE_MIN_MS, 48'hFFFF);
      write_register(CSR_DOWN_ONLY_KEY, 48'd48);
      send_sample(6'd47, 1'b1, 32'hFFFF_0000);
      send_sample(6'd47, 1'b0, 32'hFFFF_FFFF);
      send_sample(6'd47, 1'b1, 32'h0000_0000);
      send_sample(6'd47, 1'b0, 32'h0000_0001);
      write_register(CSR_DOWN_ONLY_KEY, 48'd63);
      send_sample(6'd12, 1'b1, 32'h8000_0000);
      write_register(CSR_VALID_KEY_MASK, '0);
      send_sample(6'd0, 1'b1, 32'd123);
      send_sample(6'd47, 1'b0, 32'h7FFF_FFFF);
   endtask

   // Hold the event channel off while presses keep coming, so the core stalls its input.
   task automatic test_input_stall();
      write_register(CSR_VALID_KEY_MASK, {MaskW{1'b1}});
      write_register(CSR_DOWN_ONLY_KEY, 48'd40);
      quiet_mode = 1'b1;
      hold_off_request = 1'b1;
      for (int i = 16; i < 40; i++) send_sample(i[KeyW-1:0], 1'b1, 32'd5000 + i);
      wait_idle();
      quiet_mode = 1'b0;
   endtask

   // Press, hold and release sequences on a small working set of keys, with noise.
   task automatic test_random_sequences();
      logic [KeyW-1:0]  work_keys [6];
      logic [KeyW-1:0]  key;
      logic [TimeW-1:0] now_ms;
      logic [MaskW-1:0] mask;
      logic [MsW-1:0]   long_ms;
      logic             pressed;
      bit               finger_down [MaxKeys];
      int               useful;
      for (int phase = 0; phase < 6; phase++) begin
         long_ms = MsW'($urandom_range(20, 400));
         for (int i = 0; i < 6; i++) work_keys[i] = KeyW'($urandom_range(0, NumKeys - 1));
         mask = (phase == 0) ? {MaskW{1'b1}}
                             : MaskW'({$urandom, $urandom} | {$urandom, $urandom});
         // At least one working key stays real so the phase always makes progress.
         mask[work_keys[0]] = 1'b1;
         write_register(CSR_LONG_PRESS_MS, MaskW'(long_ms));
         write_register(CSR_RELEASE_MIN_MS, MaskW'($urandom_range(0, long_ms)));
         write_register(CSR_VALID_KEY_MASK, mask);
         write_register(CSR_DOWN_ONLY_KEY,
                        phase[0] ? MaskW'(work_keys[0]) : MaskW'($urandom_range(0, 63)));
         quiet_mode = (phase == 2);
         for (int i = 0; i < MaxKeys; i++) finger_down[i] = 1'b0;
         now_ms = $urandom;
         useful = 0;
         while (useful < 110) begin
            if ($urandom_range(0, 19) == 0) key = KeyW'($urandom_range(NumKeys, 63));
            else key = work_keys[$urandom_range(0, 5)];
            // Mostly clean press and release, with the occasional bounce and time jump.
            if (key < NumKeys && $urandom_range(0, 3) == 0) finger_down[key] = !finger_down[key];
            pressed = (key < NumKeys) ? finger_down[key] : 1'($urandom_range(0, 1));
            if ($urandom_range(0, 19) == 0) pressed = !pressed;
            if ($urandom_range(0, 49) == 0) now_ms = now_ms + $urandom;
            else now_ms = now_ms + $urandom_range(0, long_ms / 6 + 2);
            send_sample(key, pressed, now_ms);
            if (key < NumKeys && mask[key]) useful++;
         end
      end
      quiet_mode = 1'b0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_registers();
      test_register_extremes();
      test_input_stall();
      test_random_sequences();
      wait_idle();
      if (error_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #2_000_000;
      $display("testbench failed");
      $finish;
   end

endmodule
